/* rtl/tlpq_pkg.sv */
package tlpq_pkg;

  localparam int unsigned CmdW = 8;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SKIP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } fifo_ctrl_t;

  typedef struct packed {
    logic            nonempty;
    logic            full;
    logic [CmdW-1:0] head;
    logic            nonempty_next;
    logic [CmdW-1:0] head_next;
  } fifo_stat_t;

endpackage

/* rtl/two_level_priority_op_queue.sv */
// The result of an accepted request is registered into the output register.
// Throughput: one request per cycle; a request updates at most one queue's fill count
// and shift slots, or clears both, and forms the served head in the same cycle.
// The input side stays ready while the output register is empty or being drained.
// Reset (rst_ni low, asynchronous) empties both queues and clears the output valid.
module two_level_priority_op_queue
  import tlpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [1:0] operation, [9:2] command_byte, [15:10] zero
  input  logic        s_tuser_i,   // [0] urgent
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [1:0] status, [2] head_valid, [10:3] head_command,
                                   // [15:11] zero
  output logic        m_tuser_o    // [0] head_is_urgent
);

  logic [1:0]      operation;
  logic [CmdW-1:0] command_byte;
  logic            urgent;
  logic            accept;

  fifo_ctrl_t      urg_ctrl, nrm_ctrl;
  fifo_stat_t      urg_stat, nrm_stat;
  fifo_stat_t      sel_stat;

  logic [1:0]      status;
  logic            is_add;

  logic            m_valid_q;
  logic [1:0]      status_q;
  logic            head_valid_q;
  logic [CmdW-1:0] head_command_q;
  logic            head_is_urgent_q;

  assign operation    = s_tdata_i[1:0];
  assign command_byte = s_tdata_i[9:2];
  assign urgent       = s_tuser_i;

  assign s_tready_o = !m_valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  assign is_add   = accept && (operation == OP_ADD);
  assign sel_stat = urgent ? urg_stat : nrm_stat;

  always_comb begin
    status = ST_DONE;
    if (operation == OP_ADD) begin
      if (sel_stat.nonempty && (sel_stat.head == command_byte)) begin
        status = ST_DUP;
      end else if (sel_stat.full) begin
        status = ST_FULL;
      end else begin
        status = ST_ADDED;
      end
    end
  end

  always_comb begin
    urg_ctrl.push = is_add && urgent && (status == ST_ADDED);
    nrm_ctrl.push = is_add && !urgent && (status == ST_ADDED);
    // Skip serves the urgent queue first.
    urg_ctrl.pop  = accept && (operation == OP_SKIP) && urg_stat.nonempty;
    nrm_ctrl.pop  = accept && (operation == OP_SKIP) && !urg_stat.nonempty;
    urg_ctrl.clr  = accept && (operation == OP_CLEAR);
    nrm_ctrl.clr  = accept && (operation == OP_CLEAR);
  end

  tlpq_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_urgent (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (urg_ctrl),
    .cmd_i  (command_byte),
    .stat_o (urg_stat)
  );

  tlpq_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_normal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nrm_ctrl),
    .cmd_i  (command_byte),
    .stat_o (nrm_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      if (urg_stat.nonempty_next) begin
        head_valid_q     <= 1'b1;
        head_command_q   <= urg_stat.head_next;
        head_is_urgent_q <= 1'b1;
      end else if (nrm_stat.nonempty_next) begin
        head_valid_q     <= 1'b1;
        head_command_q   <= nrm_stat.head_next;
        head_is_urgent_q <= 1'b0;
      end else begin
        head_valid_q     <= 1'b0;
        head_command_q   <= '0;
        head_is_urgent_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {5'd0, head_command_q, head_valid_q, status_q};
  assign m_tuser_o  = head_is_urgent_q;

endmodule

/* rtl/tlpq_fifo.sv */
module tlpq_fifo
  import tlpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fifo_ctrl_t      ctrl_i,
  input  logic [CmdW-1:0] cmd_i,
  output fifo_stat_t      stat_o
);

  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(QUEUE_DEPTH);

  // Shift queue: slot 0 always holds the head.
  logic [CmdW-1:0]  entries_q [QUEUE_DEPTH];
  logic [CmdW-1:0]  entries_d [QUEUE_DEPTH];
  logic [FillW-1:0] fill_q, fill_d;
  logic             nonempty;
  logic             do_pop;

  assign nonempty = (fill_q != '0);
  assign do_pop   = ctrl_i.pop && nonempty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        entries_d[i] = entries_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
      if (ctrl_i.push && (fill_q[IdxW-1:0] == IdxW'(i))) begin
        entries_d[i] = cmd_i;
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clr) begin
      fill_d = '0;
    end else if (ctrl_i.push) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  always_comb begin
    stat_o.nonempty      = nonempty;
    stat_o.full          = (fill_q == FillW'(QUEUE_DEPTH));
    stat_o.head          = entries_q[0];
    stat_o.nonempty_next = (fill_d != '0);
    if (do_pop) begin
      stat_o.head_next = entries_q[1];
    end else if (ctrl_i.push && !nonempty) begin
      stat_o.head_next = cmd_i;
    end else begin
      stat_o.head_next = entries_q[0];
    end
  end

endmodule
